FILE: hw/rtl/deq_pkg.sv
// ----------------------------------------------------------------------------
// deq_pkg
// Shared sizes, command and status codes and ring index helpers for the
// double-ended queue unit.
// ----------------------------------------------------------------------------
package deq_pkg;

    localparam int DEPTH      = 16;
    localparam int DATA_WIDTH = 32;

    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int SUM_W  = ADDR_W + 1;

    localparam int OP_W    = 3;
    localparam int VALUE_W = 32;
    localparam int COUNT_W = 5;
    localparam int ERR_W   = 2;

    typedef enum logic [OP_W-1:0] {
        OP_PUSH_FRONT = 3'd0,
        OP_PUSH_BACK  = 3'd1,
        OP_POP_FRONT  = 3'd2,
        OP_POP_BACK   = 3'd3,
        OP_REVERSE    = 3'd4,
        OP_REPORT     = 3'd5
    } op_t;

    typedef enum logic [ERR_W-1:0] {
        ERR_OK    = 2'd0,
        ERR_EMPTY = 2'd1,
        ERR_FULL  = 2'd2
    } err_t;

    typedef logic [ADDR_W-1:0] addr_t;
    typedef logic [CNT_W-1:0]  cnt_t;

    // sum is below twice the depth, so one compare and subtract wraps it
    function automatic addr_t ring_wrap(input logic [SUM_W-1:0] sum);
        logic [SUM_W-1:0] red;
        red = (sum >= SUM_W'(DEPTH)) ? sum - SUM_W'(DEPTH) : sum;
        return red[ADDR_W-1:0];
    endfunction

    function automatic addr_t ring_inc(input addr_t idx);
        return (idx == addr_t'(DEPTH - 1)) ? '0 : idx + addr_t'(1);
    endfunction

    function automatic addr_t ring_dec(input addr_t idx);
        return (idx == '0) ? addr_t'(DEPTH - 1) : idx - addr_t'(1);
    endfunction

endpackage

FILE: hw/rtl/deq_ram.sv
// ----------------------------------------------------------------------------
// deq_ram
// Generic ring store: one write port, two read ports, registered read data
// that returns the old contents on a same-address write.
// ----------------------------------------------------------------------------
module deq_ram #(
    parameter int DEPTH = 16,
    parameter int WIDTH = 32,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr_a,
    input  logic [AW-1:0]    raddr_b,
    output logic [WIDTH-1:0] rdata_a,
    output logic [WIDTH-1:0] rdata_b
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_a <= mem[raddr_a];
        rdata_b <= mem[raddr_b];
    end

endmodule

FILE: hw/rtl/double_ended_queue_unit.sv
// ----------------------------------------------------------------------------
// double_ended_queue_unit
// Bounded double-ended queue kept in a ring store with head, count and a
// reversed flag.
// ----------------------------------------------------------------------------
// The s_ channel carries one command item (s_op, s_value); the m_ channel
// returns one result item per command: logical front and back words, the
// count, an empty mark and an error code, all describing the state after
// the command.
// An item is taken in a cycle where s_ready is high. Head, count and the
// reversed flag update at that edge, a push writes the ring store and both
// ends are read from the store in the same cycle. The read data arrives in
// the next cycle; the result is loaded into the output register, raising
// m_valid, at the first edge in which that register is free. s_ready stays
// low until then, so a new item is not taken before the previous result
// has left the read stage.
// A write to an end that is read in the same cycle is forwarded.
// A result that waits on m_ready does not block the next acceptance; the
// following result waits in the read stage until the output register frees,
// and the ends are read again from the updated state while it waits.
// Reset (aresetn low at a clock edge) empties the deque, clears the reversed
// flag and drops any pending result; the store itself is not cleared.
// ----------------------------------------------------------------------------
module double_ended_queue_unit (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic [deq_pkg::OP_W-1:0]    s_op,
    input  logic [deq_pkg::VALUE_W-1:0] s_value,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic [deq_pkg::VALUE_W-1:0] m_front_value,
    output logic [deq_pkg::VALUE_W-1:0] m_back_value,
    output logic [deq_pkg::COUNT_W-1:0] m_count,
    output logic                        m_empty_res,
    output logic [deq_pkg::ERR_W-1:0]   m_error
);

    import deq_pkg::*;

    typedef enum logic {
        ST_IDLE,
        ST_RESULT
    } state_t;

    state_t state_reg;
    addr_t  head_reg, head_next;
    cnt_t   count_reg, count_next;
    logic   rev_reg, rev_next;
    err_t   err_reg, err_next;
    logic   fwd_a_reg, fwd_b_reg;
    logic [DATA_WIDTH-1:0] wdata_reg;
    logic   m_valid_reg;
    logic [VALUE_W-1:0] front_reg, back_reg;
    logic [COUNT_W-1:0] count_out_reg;
    logic   empty_reg;
    err_t   err_out_reg;

    logic  accept, out_free;
    logic  is_push, is_pop, at_start, full, empty;
    logic  we;
    addr_t waddr, raddr_a, raddr_b;
    logic [DATA_WIDTH-1:0] wdata, rdata_a, rdata_b, first_w, last_w;
    logic [63:0] value_ext, front_ext, back_ext;

    assign accept   = s_valid && s_ready;
    assign s_ready  = (state_reg == ST_IDLE);
    assign out_free = !m_valid_reg || m_ready;

    assign full      = (count_reg == cnt_t'(DEPTH));
    assign empty     = (count_reg == '0);
    assign is_push   = (s_op == OP_PUSH_FRONT) || (s_op == OP_PUSH_BACK);
    assign is_pop    = (s_op == OP_POP_FRONT) || (s_op == OP_POP_BACK);
    // logical front maps to the physical start unless reversed
    assign at_start  = ((s_op == OP_PUSH_FRONT) || (s_op == OP_POP_FRONT)) != rev_reg;
    assign value_ext = {32'd0, s_value};
    assign wdata     = value_ext[DATA_WIDTH-1:0];

    always_comb begin
        head_next  = head_reg;
        count_next = count_reg;
        rev_next   = rev_reg;
        err_next   = ERR_OK;
        we         = 1'b0;
        waddr      = at_start ? ring_dec(head_reg)
                              : ring_wrap(SUM_W'(head_reg) + SUM_W'(count_reg));
        if (is_push) begin
            if (full) begin
                err_next = ERR_FULL;
            end else begin
                we         = accept;
                head_next  = at_start ? ring_dec(head_reg) : head_reg;
                count_next = count_reg + cnt_t'(1);
            end
        end else if (is_pop) begin
            if (empty) begin
                err_next = ERR_EMPTY;
            end else begin
                head_next  = at_start ? ring_inc(head_reg) : head_reg;
                count_next = count_reg - cnt_t'(1);
            end
        end else if (s_op == OP_REVERSE) begin
            rev_next = !rev_reg;
        end
    end

    // outside an accepting cycle the ends of the current state are read
    assign raddr_a = accept ? head_next : head_reg;
    assign raddr_b = accept ? ring_dec(ring_wrap(SUM_W'(head_next) + SUM_W'(count_next)))
                            : ring_dec(ring_wrap(SUM_W'(head_reg) + SUM_W'(count_reg)));

    deq_ram #(
        .DEPTH (DEPTH),
        .WIDTH (DATA_WIDTH)
    ) u_ram (
        .aclk    (aclk),
        .we      (we),
        .waddr   (waddr),
        .wdata   (wdata),
        .raddr_a (raddr_a),
        .raddr_b (raddr_b),
        .rdata_a (rdata_a),
        .rdata_b (rdata_b)
    );

    assign first_w   = fwd_a_reg ? wdata_reg : rdata_a;
    assign last_w    = fwd_b_reg ? wdata_reg : rdata_b;
    assign front_ext = empty ? 64'd0 : 64'(rev_reg ? last_w : first_w);
    assign back_ext  = empty ? 64'd0 : 64'(rev_reg ? first_w : last_w);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            head_reg    <= '0;
            count_reg   <= '0;
            rev_reg     <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            if (out_free) begin
                m_valid_reg <= (state_reg == ST_RESULT);
            end
            unique case (state_reg)
                ST_IDLE: begin
                    if (accept) begin
                        head_reg  <= head_next;
                        count_reg <= count_next;
                        rev_reg   <= rev_next;
                        err_reg   <= err_next;
                        wdata_reg <= wdata;
                        fwd_a_reg <= we && (waddr == raddr_a);
                        fwd_b_reg <= we && (waddr == raddr_b);
                        state_reg <= ST_RESULT;
                    end
                end
                ST_RESULT: begin
                    if (out_free) begin
                        front_reg     <= front_ext[VALUE_W-1:0];
                        back_reg      <= back_ext[VALUE_W-1:0];
                        count_out_reg <= COUNT_W'(count_reg);
                        empty_reg     <= empty;
                        err_out_reg   <= err_reg;
                        state_reg     <= ST_IDLE;
                    end else begin
                        // the re-read already sees the written entry
                        fwd_a_reg <= 1'b0;
                        fwd_b_reg <= 1'b0;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_front_value = front_reg;
    assign m_back_value  = back_reg;
    assign m_count       = count_out_reg;
    assign m_empty_res   = empty_reg;
    assign m_error       = err_out_reg;

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= cnt_t'(DEPTH))
        else $error("count exceeds depth");

    a_full_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && is_push && full) |=> (count_reg == $past(count_reg)))
        else $error("push on full changed the count");

    a_empty_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_empty_res) |-> (m_front_value == '0 && m_back_value == '0))
        else $error("empty result carries nonzero ends");

    a_accept_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> !s_ready)
        else $error("item accepted while the previous one is in flight");

endmodule
